// ----- rtl/sorted_key_table_unit_defines.svh -----
//------------------------------------------------------------------------------
// sorted_key_table_unit_defines
// Assertion macros used by the checker file of the sorted key table.
//------------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_TABLE_UNIT_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SKT_ASSERT_SAME(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// skt_pkg
// Types, widths and codes for the sorted key table.
//------------------------------------------------------------------------------
package skt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int STAT_W  = 2;
    localparam int POS_W   = 4;
    localparam int FILL_W  = 5;
    localparam int ENTRY_W = KEY_W + PAY_W;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_FIELD_W = POS_W + PAY_W + FILL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SRCH = 6'b000010,
        S_CMP  = 6'b000100,
        S_MOVE = 6'b001000,
        S_MVW  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    // one probe of the search: bounds are lo (inclusive) and hi (exclusive)
    typedef struct packed {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic [KEY_W-1:0] want;
        logic [KEY_W-1:0] have;
        logic             exact;
    } t_step_req;

    typedef struct packed {
        logic [IDX_W-1:0] mid;
        logic [CNT_W-1:0] lo_nx;
        logic [CNT_W-1:0] hi_nx;
        logic             hit;
        logic             active;
    } t_step_res;

endpackage

// ----- rtl/sorted_key_table_unit.sv -----
`timescale 1ns / 1ps
// An insert into a full table and the unused function code go straight to the result;
// otherwise each search probe is a RAM read and then a compare in the search unit.
// Insert and delete then move entries one at a time, each a RAM read and then a write.
// One operation at a time: a new input is taken only once the previous result has been
// handed to the output register; a result waits while stalled.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
//------------------------------------------------------------------------------
// sorted_key_table_unit
// Table of signed keys with payloads in ascending order: insert, binary
// search lookup and delete, sequenced over one RAM and one compare unit.
//------------------------------------------------------------------------------
module sorted_key_table_unit
    import skt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // key[31:0], payload_in[63:32]
    input  logic [FUNC_W-1:0]      s_axis_tuser,  // func[1:0]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // position[3:0], payload_out[35:4],
                                                  // fill_count[40:36], zero pad
    output logic [STAT_W-1:0]      m_axis_tuser   // status[1:0]
);

    t_state           r_state, n_state;
    logic [FUNC_W-1:0] r_func, n_func;
    logic [KEY_W-1:0] r_key, n_key;
    logic [PAY_W-1:0] r_pay, n_pay;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [CNT_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_count, n_count;
    logic [STAT_W-1:0] r_status, n_status;
    logic [PAY_W-1:0] r_pout, n_pout;
    logic             r_ovalid, n_ovalid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [IDX_W-1:0] r_o_pos, n_o_pos;
    logic [PAY_W-1:0] r_o_pout, n_o_pout;
    logic [CNT_W-1:0] r_o_fill, n_o_fill;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    t_step_req step_req;
    t_step_res step_res;

    logic [CNT_W-1:0] n_dec;
    logic [CNT_W-1:0] n_inc;
    logic             is_insert;

    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    skt_step u_step (
        .i_req (step_req),
        .o_res (step_res)
    );

    assign is_insert = r_func == FUNC_INSERT;
    assign n_dec     = r_n - CNT_W'(1);
    assign n_inc     = r_n + CNT_W'(1);

    always_comb begin
        step_req.lo    = r_lo;
        step_req.hi    = r_hi;
        step_req.want  = r_key;
        step_req.have  = ram_rdata[KEY_W-1:0];
        step_req.exact = !is_insert;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_key      = r_key;
        n_pay      = r_pay;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_n        = r_n;
        n_pos      = r_pos;
        n_count    = r_count;
        n_status   = r_status;
        n_pout     = r_pout;
        n_ovalid   = r_ovalid && !m_axis_tready;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_pout   = r_o_pout;
        n_o_fill   = r_o_fill;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_func   = s_axis_tuser;
                    n_key    = s_axis_tdata[KEY_W-1:0];
                    n_pay    = s_axis_tdata[KEY_W +: PAY_W];
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_status = STAT_OK;
                    n_pos    = '0;
                    n_pout   = '0;
                    case (s_axis_tuser) inside
                        FUNC_INSERT: begin
                            if (r_count == CNT_W'(TABLE_DEPTH)) begin
                                n_status = STAT_FULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        FUNC_LOOKUP, FUNC_DELETE: begin
                            n_state = S_SRCH;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (step_res.active) begin
                    ram_raddr = step_res.mid;
                    n_state   = S_CMP;
                end else if (is_insert) begin
                    n_pos   = r_lo[IDX_W-1:0];
                    n_n     = r_count;
                    n_state = S_MOVE;
                end else begin
                    n_status = STAT_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end
            S_CMP: begin
                if (step_res.hit) begin
                    n_pos  = step_res.mid;
                    n_pout = ram_rdata[KEY_W +: PAY_W];
                    if (r_func == FUNC_DELETE) begin
                        n_n     = CNT_W'(step_res.mid);
                        n_state = S_MOVE;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    n_lo    = step_res.lo_nx;
                    n_hi    = step_res.hi_nx;
                    n_state = S_SRCH;
                end
            end
            S_MOVE: begin
                if (is_insert) begin
                    if (r_n > CNT_W'(r_pos)) begin
                        ram_raddr = n_dec[IDX_W-1:0];
                        n_state   = S_MVW;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_pos;
                        ram_wdata = {r_pay, r_key};
                        n_count   = r_count + CNT_W'(1);
                        n_state   = S_DONE;
                    end
                end else begin
                    if (n_inc < r_count) begin
                        ram_raddr = n_inc[IDX_W-1:0];
                        n_state   = S_MVW;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_MVW: begin
                ram_we    = 1'b1;
                ram_waddr = r_n[IDX_W-1:0];
                ram_wdata = ram_rdata;
                n_n       = is_insert ? n_dec : n_inc;
                n_state   = S_MOVE;
            end
            S_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid   = 1'b1;
                    n_o_status = r_status;
                    n_o_pos    = r_pos;
                    n_o_pout   = r_pout;
                    n_o_fill   = r_count;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_pay      <= n_pay;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_n        <= n_n;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_pout     <= n_pout;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_pout   <= n_o_pout;
        r_o_fill   <= n_o_fill;
    end

    assign s_axis_tready = r_state == S_IDLE;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, FILL_W'(r_o_fill), r_o_pout, POS_W'(r_o_pos)};

endmodule

// ----- rtl/skt_ram.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// skt_ram
// Generic single-write, single-read RAM with registered read data.
//------------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/skt_step.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// skt_step
// Shared search unit: midpoint, signed key compare and next bounds.
//------------------------------------------------------------------------------
module skt_step
    import skt_pkg::*;
(
    input  t_step_req i_req,
    output t_step_res o_res
);

    logic [CNT_W-1:0] span;
    logic [CNT_W-1:0] mid_c;
    logic             key_lt;
    logic             key_eq;
    logic             go_low;

    always_comb begin
        span   = i_req.hi - i_req.lo - CNT_W'(1);
        mid_c  = i_req.lo + (span >> 1);
        key_lt = $signed(i_req.want) < $signed(i_req.have);
        key_eq = i_req.want == i_req.have;
        // exact search narrows below on want < have, lower bound on want <= have
        go_low = i_req.exact ? key_lt : (key_lt || key_eq);

        o_res.mid    = mid_c[IDX_W-1:0];
        o_res.hit    = i_req.exact && key_eq;
        o_res.lo_nx  = go_low ? i_req.lo : (mid_c + CNT_W'(1));
        o_res.hi_nx  = go_low ? mid_c : i_req.hi;
        o_res.active = i_req.lo < i_req.hi;
    end

endmodule

// ----- rtl/skt_checker.sv -----
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// skt_checker
// Port-level checks for the sorted key table, bound to the top level.
//------------------------------------------------------------------------------
`include "sorted_key_table_unit_defines.svh"

module skt_checker
    import skt_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [STAT_W-1:0]      m_axis_tuser
);

    // fill count never exceeds the table size
    `SKT_ASSERT_SAME(a_fill_range, m_axis_tvalid, m_axis_tdata[POS_W+PAY_W +: FILL_W] <= FILL_W'(TABLE_DEPTH), "fill count above table depth")

    // failed operations report zero position and payload
    `SKT_ASSERT_SAME(a_fail_zero, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata[POS_W+PAY_W-1:0] == '0, "nonzero position or payload on failure")

    // one operation at a time: busy right after a transfer in
    `SKT_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after transfer")

    // stalled result holds
    `SKT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

endmodule

bind sorted_key_table_unit skt_checker u_skt_checker (.*);
